// ===== hdl/fpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point physics calculator package
// Shared widths, action and status codes, transfer payloads and the
// side-band records that travel down the root and divider cell chains.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int WORD_BITS = 32;
  // Radicand magnitude and the integer root taken from it.
  localparam int RAD_BITS  = 2 * WORD_BITS + 2;
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int REM_BITS  = ROOT_BITS + 2;
  // Multiplier operands hold a sign-extended sum or four times a word.
  localparam int MUL_BITS  = WORD_BITS + 3;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;

  typedef enum logic [3:0] {
    ACT_MUL   = 4'd0,
    ACT_DIV   = 4'd1,
    ACT_ADD   = 4'd2,
    ACT_SUB   = 4'd3,
    ACT_INTER = 4'd4,
    ACT_QUAD  = 4'd5,
    ACT_LEN3  = 4'd6,
    ACT_LEN4  = 4'd7,
    ACT_MASS  = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMPLEX  = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_UNPHYS   = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef logic signed [WORD_BITS:0]    wide1_t;
  typedef logic signed [MUL_BITS-1:0]   mul_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    logic [3:0]                  action;
    logic signed [WORD_BITS-1:0] operand_0;
    logic signed [WORD_BITS-1:0] operand_1;
    logic signed [WORD_BITS-1:0] operand_2;
    logic signed [WORD_BITS-1:0] operand_3;
    logic signed [WORD_BITS-1:0] operand_4;
    logic signed [WORD_BITS-1:0] operand_5;
    logic signed [WORD_BITS-1:0] operand_6;
    logic signed [WORD_BITS-1:0] operand_7;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_main;
    logic signed [WORD_BITS-1:0] result_second;
    status_t                     status;
    logic                        saturated;
  } out_item_t;

  // Carried through the multiply stages.
  typedef struct packed {
    action_t                     action;
    logic signed [WORD_BITS-1:0] op_a;
    logic signed [WORD_BITS-1:0] op_b;
    wide1_t                      as_sum;
  } fr_side_t;

  // Carried alongside the root chain.
  typedef struct packed {
    action_t                     action;
    logic signed [WORD_BITS-1:0] op_a;
    logic signed [WORD_BITS-1:0] op_b;
    logic                        neg;
    logic                        dneg;
    logic [RAD_BITS-1:0]         dmag;
  } sq_side_t;

  // Carried alongside the divider chain.
  typedef struct packed {
    status_t             status;
    logic                use_q;
    logic                neg0;
    logic                neg1;
    logic                dneg;
    logic [RAD_BITS-1:0] dmag;
  } dv_side_t;

endpackage

// ===== hdl/fixed_point_physics_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point physics calculator
// Signed fixed-point arithmetic, line intercept, quadratic roots, vector and
// Minkowski lengths and two-particle invariant mass.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  in_      in_valid/in_stall    in_item  (action, operand_0..operand_7)
//  out_     out_valid/out_stall  out_item (result_main, result_second,
//                                          status, saturated)
//
// A new item can be taken every cycle while in_stall is low. Each result
// passes through five front stages, one root cell per root bit,
// one setup stage, one divider cell per quotient bit and the output register.
// Reset clears only the valid flags of the stages. A stalled output holds
// its result; stages behind it keep filling until every stage is occupied.
// ----------------------------------------------------------------------------
module fixed_point_physics_calculator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fpc_pkg::out_item_t  out_item
);

  localparam int W    = fpc_pkg::WORD_BITS;
  localparam int RADW = fpc_pkg::RAD_BITS;
  localparam int RTW  = fpc_pkg::ROOT_BITS;
  localparam int REMW = fpc_pkg::REM_BITS;
  localparam int SUMW = fpc_pkg::SUM_BITS;
  localparam int OPW  = W + 3;
  localparam int NW   = W + 2 + FRAC_BITS;
  localparam int DW   = W + 1;
  localparam int XW   = (NW > RADW) ? NW : RADW;
  localparam logic [XW-1:0] LIM_POS = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] LIM_NEG = {{(XW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // Returns {clamped, word}.
  function automatic logic [W:0] sat_word(input logic neg, input logic [XW-1:0] mag);
    logic [W-1:0] v;
    logic         s;
    s = 1'b0;
    if (!neg) begin
      if (mag > LIM_POS) begin
        v = LIM_POS[W-1:0];
        s = 1'b1;
      end else begin
        v = mag[W-1:0];
      end
    end else begin
      if (mag > LIM_NEG) begin
        v = LIM_NEG[W-1:0];
        s = 1'b1;
      end else begin
        v = W'(~mag[W-1:0] + 1'b1);
      end
    end
    return {s, v};
  endfunction

  // -------------------------------------------------------------------------
  // Front stages: input register, operand select, multiply, two-level sum.
  // -------------------------------------------------------------------------
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r;
  logic a_stall, b_stall, c_stall, d_stall, e_stall;

  fpc_pkg::in_item_t  a_item_r;
  fpc_pkg::fr_side_t  b_side_r, b_side_nxt, c_side_r, d_side_r;
  fpc_pkg::mul_t      b_l_r [4];
  fpc_pkg::mul_t      b_r_r [4];
  fpc_pkg::mul_t      b_l_nxt [4];
  fpc_pkg::mul_t      b_r_nxt [4];
  fpc_pkg::prod_t     c_p_r [4];
  fpc_pkg::sum_t      d_s01_r, d_s23_r;
  fpc_pkg::sq_side_t  e_side_r, e_side_nxt;
  logic [RADW-1:0]    e_rad_r, e_rad_nxt;

  fpc_pkg::wide1_t    sum_e, sum_px, sum_py, sum_pz;
  fpc_pkg::sum_t      e_sum;
  logic [SUMW-1:0]    e_mag;
  logic [W:0]         as_mag;

  logic                      sq_valid [RTW+1];
  logic                      sq_stall [RTW+2];
  fpc_pkg::sq_side_t         sq_side  [RTW+1];
  logic [RADW-1:0]           sq_rad   [RTW+1];
  logic [REMW-1:0]           sq_rem   [RTW+1];
  logic [RTW-1:0]            sq_root  [RTW+1];

  logic                      dv_valid [NW+1];
  logic                      dv_stall [NW+2];
  fpc_pkg::dv_side_t         dv_side  [NW+1];
  logic [DW-1:0]             dv_den   [NW+1];
  logic [1:0][NW-1:0]        dv_nq    [NW+1];
  logic [1:0][DW-1:0]        dv_rm    [NW+1];

  assign a_stall  = a_valid_r & b_stall;
  assign b_stall  = b_valid_r & c_stall;
  assign c_stall  = c_valid_r & d_stall;
  assign d_stall  = d_valid_r & e_stall;
  assign e_stall  = e_valid_r & sq_stall[1];
  assign in_stall = a_stall;

  always_comb begin
    sum_e  = fpc_pkg::wide1_t'(a_item_r.operand_0) + fpc_pkg::wide1_t'(a_item_r.operand_1);
    sum_px = fpc_pkg::wide1_t'(a_item_r.operand_2) + fpc_pkg::wide1_t'(a_item_r.operand_3);
    sum_py = fpc_pkg::wide1_t'(a_item_r.operand_4) + fpc_pkg::wide1_t'(a_item_r.operand_5);
    sum_pz = fpc_pkg::wide1_t'(a_item_r.operand_6) + fpc_pkg::wide1_t'(a_item_r.operand_7);
    for (int i = 0; i < 4; i++) begin
      b_l_nxt[i] = '0;
      b_r_nxt[i] = '0;
    end
    b_side_nxt.action = fpc_pkg::action_t'(a_item_r.action);
    b_side_nxt.op_a   = a_item_r.operand_0;
    b_side_nxt.op_b   = a_item_r.operand_1;
    b_side_nxt.as_sum = sum_e;
    // Negative terms are folded into the left operand so that one
    // signed sum of four products serves every product-based action.
    case (fpc_pkg::action_t'(a_item_r.action))
      fpc_pkg::ACT_MUL: begin
        b_l_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_0);
        b_r_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_1);
      end
      fpc_pkg::ACT_SUB: begin
        b_side_nxt.as_sum = fpc_pkg::wide1_t'(a_item_r.operand_0)
                          - fpc_pkg::wide1_t'(a_item_r.operand_1);
      end
      fpc_pkg::ACT_QUAD: begin
        b_l_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_1);
        b_r_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_1);
        b_l_nxt[1] = -(fpc_pkg::mul_t'(a_item_r.operand_0) <<< 2);
        b_r_nxt[1] = fpc_pkg::mul_t'(a_item_r.operand_2);
      end
      fpc_pkg::ACT_LEN3: begin
        b_l_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_0);
        b_r_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_0);
        b_l_nxt[1] = fpc_pkg::mul_t'(a_item_r.operand_1);
        b_r_nxt[1] = fpc_pkg::mul_t'(a_item_r.operand_1);
        b_l_nxt[2] = fpc_pkg::mul_t'(a_item_r.operand_2);
        b_r_nxt[2] = fpc_pkg::mul_t'(a_item_r.operand_2);
      end
      fpc_pkg::ACT_LEN4: begin
        b_l_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_0);
        b_r_nxt[0] = fpc_pkg::mul_t'(a_item_r.operand_0);
        b_l_nxt[1] = -fpc_pkg::mul_t'(a_item_r.operand_1);
        b_r_nxt[1] = fpc_pkg::mul_t'(a_item_r.operand_1);
        b_l_nxt[2] = -fpc_pkg::mul_t'(a_item_r.operand_2);
        b_r_nxt[2] = fpc_pkg::mul_t'(a_item_r.operand_2);
        b_l_nxt[3] = -fpc_pkg::mul_t'(a_item_r.operand_3);
        b_r_nxt[3] = fpc_pkg::mul_t'(a_item_r.operand_3);
      end
      fpc_pkg::ACT_MASS: begin
        b_l_nxt[0] = fpc_pkg::mul_t'(sum_e);
        b_r_nxt[0] = fpc_pkg::mul_t'(sum_e);
        b_l_nxt[1] = -fpc_pkg::mul_t'(sum_px);
        b_r_nxt[1] = fpc_pkg::mul_t'(sum_px);
        b_l_nxt[2] = -fpc_pkg::mul_t'(sum_py);
        b_r_nxt[2] = fpc_pkg::mul_t'(sum_py);
        b_l_nxt[3] = -fpc_pkg::mul_t'(sum_pz);
        b_r_nxt[3] = fpc_pkg::mul_t'(sum_pz);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    e_sum  = d_s01_r + d_s23_r;
    e_mag  = e_sum[SUMW-1] ? -e_sum : e_sum;
    as_mag = d_side_r.as_sum[W] ? -d_side_r.as_sum : d_side_r.as_sum;
    e_side_nxt.action = d_side_r.action;
    e_side_nxt.op_a   = d_side_r.op_a;
    e_side_nxt.op_b   = d_side_r.op_b;
    e_side_nxt.neg    = e_sum[SUMW-1];
    e_side_nxt.dneg   = 1'b0;
    e_side_nxt.dmag   = '0;
    case (d_side_r.action)
      fpc_pkg::ACT_MUL: begin
        e_side_nxt.dneg = e_sum[SUMW-1];
        e_side_nxt.dmag = RADW'(e_mag >> FRAC_BITS);
      end
      fpc_pkg::ACT_ADD, fpc_pkg::ACT_SUB: begin
        e_side_nxt.dneg = d_side_r.as_sum[W];
        e_side_nxt.dmag = RADW'(as_mag);
      end
      default: begin
      end
    endcase
    e_rad_nxt = e_mag[RADW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (!a_stall) a_valid_r <= in_valid;
      if (!b_stall) b_valid_r <= a_valid_r;
      if (!c_stall) c_valid_r <= b_valid_r;
      if (!d_stall) d_valid_r <= c_valid_r;
      if (!e_stall) e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_stall) a_item_r <= in_item;
    if (!b_stall) begin
      b_side_r <= b_side_nxt;
      for (int i = 0; i < 4; i++) begin
        b_l_r[i] <= b_l_nxt[i];
        b_r_r[i] <= b_r_nxt[i];
      end
    end
    if (!c_stall) begin
      c_side_r <= b_side_r;
      for (int i = 0; i < 4; i++) begin
        c_p_r[i] <= b_l_r[i] * b_r_r[i];
      end
    end
    if (!d_stall) begin
      d_side_r <= c_side_r;
      d_s01_r  <= fpc_pkg::sum_t'(c_p_r[0]) + fpc_pkg::sum_t'(c_p_r[1]);
      d_s23_r  <= fpc_pkg::sum_t'(c_p_r[2]) + fpc_pkg::sum_t'(c_p_r[3]);
    end
    if (!e_stall) begin
      e_side_r <= e_side_nxt;
      e_rad_r  <= e_rad_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Root chain: one cell per root bit.
  // -------------------------------------------------------------------------
  assign sq_valid[0]    = e_valid_r;
  assign sq_stall[0]    = e_stall;
  assign sq_side[0]     = e_side_r;
  assign sq_rad[0]      = e_rad_r;
  assign sq_rem[0]      = '0;
  assign sq_root[0]     = '0;
  assign sq_stall[RTW+1] = dv_stall[0];

  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    fpc_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_valid[k]),
      .stall_i (sq_stall[k+2]),
      .side_i  (sq_side[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .valid_o (sq_valid[k+1]),
      .stall_o (sq_stall[k+1]),
      .side_o  (sq_side[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1])
    );
  end

  // -------------------------------------------------------------------------
  // Divider setup: numerators, divisor and status per action.
  // -------------------------------------------------------------------------
  logic               g_valid_r;
  fpc_pkg::dv_side_t  g_side_r, g_side_nxt;
  logic [DW-1:0]      g_den_r, g_den_nxt;
  logic [1:0][NW-1:0] g_nq_r, g_nq_nxt;

  logic signed [OPW-1:0] g_a, g_b, g_nb, g_root, g_t0, g_t1, g_dd;
  logic [OPW-1:0]        g_m0, g_m1, g_md;

  always_comb begin
    g_a    = OPW'(sq_side[RTW].op_a);
    g_b    = OPW'(sq_side[RTW].op_b);
    g_nb   = -g_b;
    g_root = $signed({2'b00, sq_root[RTW]});
    g_t0   = '0;
    g_t1   = '0;
    g_dd   = '0;
    g_side_nxt.status = fpc_pkg::ST_OK;
    g_side_nxt.use_q  = 1'b0;
    g_side_nxt.dneg   = 1'b0;
    g_side_nxt.dmag   = '0;
    case (sq_side[RTW].action)
      fpc_pkg::ACT_MUL, fpc_pkg::ACT_ADD, fpc_pkg::ACT_SUB: begin
        g_side_nxt.dneg = sq_side[RTW].dneg;
        g_side_nxt.dmag = sq_side[RTW].dmag;
      end
      fpc_pkg::ACT_DIV: begin
        if (sq_side[RTW].op_b == '0) begin
          g_side_nxt.status = fpc_pkg::ST_DIV_ZERO;
        end else begin
          g_side_nxt.use_q = 1'b1;
          g_t0 = g_a;
          g_dd = g_b;
        end
      end
      fpc_pkg::ACT_INTER: begin
        if (sq_side[RTW].op_a == '0) begin
          g_side_nxt.status = fpc_pkg::ST_DIV_ZERO;
        end else begin
          g_side_nxt.use_q = 1'b1;
          g_t0 = g_nb;
          g_dd = g_a;
        end
      end
      fpc_pkg::ACT_QUAD: begin
        if (sq_side[RTW].op_a == '0) begin
          g_side_nxt.status = fpc_pkg::ST_DIV_ZERO;
        end else begin
          g_side_nxt.use_q = 1'b1;
          g_dd = g_a <<< 1;
          if (!sq_side[RTW].neg) begin
            g_t0 = g_nb + g_root;
            g_t1 = g_nb - g_root;
          end else begin
            // Negative discriminant: real part and imaginary part.
            g_side_nxt.status = fpc_pkg::ST_COMPLEX;
            g_t0 = g_nb;
            g_t1 = g_root;
          end
        end
      end
      fpc_pkg::ACT_LEN3, fpc_pkg::ACT_LEN4: begin
        g_side_nxt.dmag = RADW'(sq_root[RTW]);
      end
      fpc_pkg::ACT_MASS: begin
        if (sq_side[RTW].neg) begin
          g_side_nxt.status = fpc_pkg::ST_UNPHYS;
        end else begin
          g_side_nxt.dmag = RADW'(sq_root[RTW]);
        end
      end
      default: begin
        g_side_nxt.status = fpc_pkg::ST_INVALID;
      end
    endcase
    g_side_nxt.neg0 = g_t0[OPW-1] ^ g_dd[OPW-1];
    g_side_nxt.neg1 = g_t1[OPW-1] ^ g_dd[OPW-1];
    g_m0 = g_t0[OPW-1] ? -g_t0 : g_t0;
    g_m1 = g_t1[OPW-1] ? -g_t1 : g_t1;
    g_md = g_dd[OPW-1] ? -g_dd : g_dd;
    g_nq_nxt[0] = NW'(g_m0) << FRAC_BITS;
    g_nq_nxt[1] = NW'(g_m1) << FRAC_BITS;
    g_den_nxt   = DW'(g_md);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (!dv_stall[0]) begin
      g_valid_r <= sq_valid[RTW];
    end
  end

  always_ff @(posedge clk) begin
    if (!dv_stall[0]) begin
      g_side_r <= g_side_nxt;
      g_den_r  <= g_den_nxt;
      g_nq_r   <= g_nq_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Divider chain: one cell per quotient bit, two lanes.
  // -------------------------------------------------------------------------
  logic h_stall;

  assign dv_valid[0]   = g_valid_r;
  assign dv_stall[0]   = g_valid_r & dv_stall[1];
  assign dv_side[0]    = g_side_r;
  assign dv_den[0]     = g_den_r;
  assign dv_nq[0]      = g_nq_r;
  assign dv_rm[0]      = '0;
  assign dv_stall[NW+1] = h_stall;

  for (genvar k = 0; k < NW; k++) begin : g_div
    fpc_div_cell #(
      .NUM_BITS (NW),
      .DEN_BITS (DW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_valid[k]),
      .stall_i (dv_stall[k+2]),
      .side_i  (dv_side[k]),
      .den_i   (dv_den[k]),
      .nq_i    (dv_nq[k]),
      .rm_i    (dv_rm[k]),
      .valid_o (dv_valid[k+1]),
      .stall_o (dv_stall[k+1]),
      .side_o  (dv_side[k+1]),
      .den_o   (dv_den[k+1]),
      .nq_o    (dv_nq[k+1]),
      .rm_o    (dv_rm[k+1])
    );
  end

  // -------------------------------------------------------------------------
  // Output register with clamping to the word range.
  // -------------------------------------------------------------------------
  logic               out_valid_r;
  fpc_pkg::out_item_t out_item_r, out_item_nxt;
  logic [XW-1:0]      h_mag0, h_mag1;
  logic               h_neg0, h_neg1;
  logic [W:0]         h_w0, h_w1;

  assign h_stall = out_valid_r & out_stall;

  always_comb begin
    if (dv_side[NW].use_q) begin
      h_mag0 = XW'(dv_nq[NW][0]);
      h_mag1 = XW'(dv_nq[NW][1]);
      h_neg0 = dv_side[NW].neg0;
      h_neg1 = dv_side[NW].neg1;
    end else begin
      h_mag0 = XW'(dv_side[NW].dmag);
      h_mag1 = '0;
      h_neg0 = dv_side[NW].dneg;
      h_neg1 = 1'b0;
    end
    h_w0 = sat_word(h_neg0, h_mag0);
    h_w1 = sat_word(h_neg1, h_mag1);
    out_item_nxt.result_main   = h_w0[W-1:0];
    out_item_nxt.result_second = h_w1[W-1:0];
    out_item_nxt.status        = dv_side[NW].status;
    out_item_nxt.saturated     = h_w0[W] | h_w1[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!h_stall) begin
      out_valid_r <= dv_valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (!h_stall) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output is free");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status == fpc_pkg::ST_DIV_ZERO ||
                    out_item_r.status == fpc_pkg::ST_UNPHYS ||
                    out_item_r.status == fpc_pkg::ST_INVALID)
    |-> out_item_r.result_main == '0 && out_item_r.result_second == '0 &&
        !out_item_r.saturated)
    else $error("error status with nonzero results");

  a_sat_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.saturated
    |-> out_item_r.status == fpc_pkg::ST_OK || out_item_r.status == fpc_pkg::ST_COMPLEX)
    else $error("saturation flagged on an error status");

  a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && b_valid_r && out_valid_r)
    else $error("input stalled with an empty stage");

endmodule

// ===== hdl/fpc_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// Settles one root bit from the next two radicand bits and passes the
// partial root, remainder and remaining radicand to the next cell.
// ----------------------------------------------------------------------------
module fpc_sqrt_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             valid_i,
  input  logic                             stall_i,
  input  fpc_pkg::sq_side_t                side_i,
  input  logic [fpc_pkg::RAD_BITS-1:0]     rad_i,
  input  logic [fpc_pkg::REM_BITS-1:0]     rem_i,
  input  logic [fpc_pkg::ROOT_BITS-1:0]    root_i,
  output logic                             valid_o,
  output logic                             stall_o,
  output fpc_pkg::sq_side_t                side_o,
  output logic [fpc_pkg::RAD_BITS-1:0]     rad_o,
  output logic [fpc_pkg::REM_BITS-1:0]     rem_o,
  output logic [fpc_pkg::ROOT_BITS-1:0]    root_o
);

  localparam int RADW = fpc_pkg::RAD_BITS;
  localparam int REMW = fpc_pkg::REM_BITS;
  localparam int RTW  = fpc_pkg::ROOT_BITS;

  logic                valid_r;
  fpc_pkg::sq_side_t   side_r;
  logic [RADW-1:0]     rad_r, rad_nxt;
  logic [REMW-1:0]     rem_r, rem_nxt;
  logic [RTW-1:0]      root_r, root_nxt;
  logic [REMW+1:0]     cand, trial;
  logic                ge;

  always_comb begin
    cand     = {rem_i, rad_i[RADW-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    ge       = (cand >= trial);
    rem_nxt  = ge ? REMW'(cand - trial) : REMW'(cand);
    root_nxt = {root_i[RTW-2:0], ge};
    rad_nxt  = {rad_i[RADW-3:0], 2'b00};
  end

  assign stall_o = valid_r & stall_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o) begin
      side_r <= side_i;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

endmodule

// ===== hdl/fpc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// Restoring division step for two quotient lanes that share one divisor.
// The numerator shifts out at the top while quotient bits shift in below.
// ----------------------------------------------------------------------------
module fpc_div_cell #(
  parameter int NUM_BITS = 50,
  parameter int DEN_BITS = 33
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic                          stall_i,
  input  fpc_pkg::dv_side_t             side_i,
  input  logic [DEN_BITS-1:0]           den_i,
  input  logic [1:0][NUM_BITS-1:0]      nq_i,
  input  logic [1:0][DEN_BITS-1:0]      rm_i,
  output logic                          valid_o,
  output logic                          stall_o,
  output fpc_pkg::dv_side_t             side_o,
  output logic [DEN_BITS-1:0]           den_o,
  output logic [1:0][NUM_BITS-1:0]      nq_o,
  output logic [1:0][DEN_BITS-1:0]      rm_o
);

  logic                       valid_r;
  fpc_pkg::dv_side_t          side_r;
  logic [DEN_BITS-1:0]        den_r;
  logic [1:0][NUM_BITS-1:0]   nq_r, nq_nxt;
  logic [1:0][DEN_BITS-1:0]   rm_r, rm_nxt;
  logic [DEN_BITS:0]          cand [2];
  logic                       ge [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cand[i]   = {rm_i[i], nq_i[i][NUM_BITS-1]};
      ge[i]     = (cand[i] >= {1'b0, den_i});
      rm_nxt[i] = ge[i] ? DEN_BITS'(cand[i] - {1'b0, den_i}) : DEN_BITS'(cand[i]);
      nq_nxt[i] = {nq_i[i][NUM_BITS-2:0], ge[i]};
    end
  end

  assign stall_o = valid_r & stall_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o) begin
      side_r <= side_i;
      den_r  <= den_i;
      nq_r   <= nq_nxt;
      rm_r   <= rm_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign den_o   = den_r;
  assign nq_o    = nq_r;
  assign rm_o    = rm_r;

endmodule
